FILE: hdl/xrng_pkg.sv
// xrng_pkg: shared types and constants for the xoshiro256** bounded generator.
// No dependencies.
package xrng_pkg;

  typedef enum logic [3:0] {
    OP_RAW    = 4'd0,
    OP_LIM32  = 4'd1,
    OP_RNG32  = 4'd2,
    OP_LIM64  = 4'd3,
    OP_RNG64  = 4'd4,
    OP_SINGLE = 4'd5,
    OP_DOUBLE = 4'd6,
    OP_BOOL   = 4'd7,
    OP_RESEED = 4'd8,
    OP_LOAD   = 4'd9,
    OP_READ   = 4'd10
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_THR_START,
    ST_THR_WAIT,
    ST_DRAW,
    ST_MUL_A,
    ST_MUL_B,
    ST_MOD_START,
    ST_MOD_WAIT,
    ST_SM_ADV,
    ST_SM_MUL_A,
    ST_SM_MUL_B,
    ST_SM_FIN,
    ST_OUT,
    ST_READ_OUT
  } state_t;

  localparam logic [63:0] SM_GAMMA = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] SM_MUL_A = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] SM_MUL_B = 64'h94D049BB133111EB;

  // Reset state: SplitMix64 expansion of seed 1.
  localparam logic [63:0] RST_W0 = 64'h910A2DEC89025CC1;
  localparam logic [63:0] RST_W1 = 64'hBEEB8DA1658EEC67;
  localparam logic [63:0] RST_W2 = 64'hF893A2EEFB32555E;
  localparam logic [63:0] RST_W3 = 64'h71C18690EE42C90B;

  localparam int unsigned NUM_REGS = 5;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [63:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] rem;
  } div_rsp_t;

  function automatic logic [63:0] rotl64(input logic [63:0] x, input int unsigned k);
    rotl64 = (x << k) | (x >> (64 - k));
  endfunction

endpackage

FILE: hdl/xrng_mul.sv
// xrng_mul: 64x64 low-half multiplier built from three 32x32 partial products,
// one per cycle. Depends on xrng_pkg.
module xrng_mul import xrng_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] prod
);

  logic [1:0]  step;
  logic        busy;
  logic [63:0] ra, rb;
  logic [31:0] pa, pb;
  logic [63:0] pp;

  always_comb begin
    pa = step[0] ? ra[63:32] : ra[31:0];
    pb = step[1] ? rb[63:32] : rb[31:0];
    pp = 64'(pa) * 64'(pb);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 2'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= 2'd0;
        ra   <= a;
        rb   <= b;
        prod <= '0;
      end else if (busy) begin
        case (step)
          2'd0:    prod <= prod + pp;
          2'd1, 2'd2: prod <= prod + {pp[31:0], 32'd0};
          default: prod <= prod;
        endcase
        if (step == 2'd2) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 2'd1;
      end
    end
  end

endmodule

FILE: hdl/xrng_div.sv
// xrng_div: 64-bit restoring remainder unit, one quotient bit per cycle.
// Depends on xrng_pkg.
module xrng_div import xrng_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic        busy;
  logic [6:0]  cnt;
  logic [63:0] num, den, rem;
  logic [64:0] shifted, diff;

  always_comb begin
    shifted = {rem, num[63]};
    diff    = shifted - {1'b0, den};
    rsp.rem = rem;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      rsp.done <= 1'b0;
      cnt      <= '0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        num  <= req.dividend;
        den  <= req.divisor;
        rem  <= '0;
      end else if (busy) begin
        num <= {num[62:0], 1'b0};
        rem <= diff[64] ? shifted[63:0] : diff[63:0];
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          busy     <= 1'b0;
          rsp.done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: hdl/xoshiro256ss_bounded_rng_core.sv
// xoshiro256** bounded generator top level: sequencer, state, config port.
// Raw/fraction/bool requests take one draw; bounded draws compute a threshold
// remainder, then a draw, then a remainder, redrawing on each rejected draw.
// One request at a time; the shared 64-bit remainder unit sets the pace.
// Reset (synchronous) loads the expansion of seed 1; registers reset to spec.
module xoshiro256ss_bounded_rng_core import xrng_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  output logic        stall,
  input  logic [3:0]  op,
  input  logic signed [63:0] lower_bound,
  input  logic signed [63:0] upper_bound,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] value,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  state_t state, state_next;
  logic [63:0] w0, w1, w2, w3;
  logic [63:0] seed_reg, lw0, lw1, lw2, lw3;
  op_t         cur_op;
  logic [63:0] lo_r, limit, thr, drawv, smv, res;
  logic [1:0]  idx;
  logic        wide;
  logic        thr_phase;

  logic        mul_start, mul_done;
  logic [63:0] mul_a, mul_b, mul_p;
  div_req_t    dreq;
  div_rsp_t    drsp;

  xrng_mul u_mul (.clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
                  .done(mul_done), .prod(mul_p));
  xrng_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // config port
  logic [2:0] ridx;
  assign ridx   = paddr[5:3];
  assign pready = 1'b1;
  always_comb begin
    case (ridx)
      3'd0:    prdata = seed_reg;
      3'd1:    prdata = lw0;
      3'd2:    prdata = lw1;
      3'd3:    prdata = lw2;
      3'd4:    prdata = lw3;
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_reg <= 64'd1;
      lw0 <= '0; lw1 <= '0; lw2 <= '0; lw3 <= '0;
    end else if (psel && penable && pwrite) begin
      case (ridx)
        3'd0:    seed_reg <= pwdata;
        3'd1:    lw0 <= pwdata;
        3'd2:    lw1 <= pwdata;
        3'd3:    lw2 <= pwdata;
        3'd4:    lw3 <= pwdata;
        default: ;
      endcase
    end
  end

  // request decode
  logic [31:0] hi32, lo32, d32;
  logic [63:0] d64;
  logic        rng32_empty, rng64_empty;
  logic        load_zero;
  logic [63:0] smv_adv;
  assign hi32 = upper_bound[31:0];
  assign lo32 = lower_bound[31:0];
  assign d32  = hi32 - lo32;
  assign d64  = upper_bound - lower_bound;
  assign rng32_empty = $signed(hi32) <= $signed(lo32);
  assign rng64_empty = upper_bound <= lower_bound;
  assign load_zero   = (lw0 | lw1 | lw2 | lw3) == 64'd0;
  assign smv_adv     = smv + SM_GAMMA;

  assign stall = (state != ST_IDLE);

  logic [31:0] draw32;
  logic        reject;
  assign draw32 = drawv[31:0];
  assign reject = wide ? (drawv >= thr) : ({32'd0, draw32} >= thr);

  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    dreq.start    = 1'b0;
    dreq.dividend = '0;
    dreq.divisor  = limit;
    case (state)
      ST_IDLE: if (valid) begin
        case (op)
          OP_RAW, OP_SINGLE, OP_DOUBLE, OP_BOOL: state_next = ST_DRAW;
          OP_LIM32: state_next = (hi32 == 32'd0 || hi32[31]) ? ST_OUT : ST_THR_START;
          OP_RNG32: state_next = rng32_empty ? ST_OUT : ST_THR_START;
          OP_LIM64: state_next = (upper_bound == 64'sd0 || upper_bound[63]) ?
                                 ST_OUT : ST_THR_START;
          OP_RNG64: state_next = rng64_empty ? ST_OUT : ST_THR_START;
          OP_RESEED: state_next = ST_SM_ADV;
          OP_LOAD: state_next = load_zero ? ST_SM_ADV : ST_IDLE;
          OP_READ: state_next = ST_READ_OUT;
          default: state_next = ST_IDLE;
        endcase
      end
      ST_THR_START: begin
        dreq.start    = 1'b1;
        dreq.dividend = wide ? 64'hFFFFFFFFFFFFFFFF : 64'h00000000FFFFFFFF;
        state_next    = ST_THR_WAIT;
      end
      ST_THR_WAIT: if (drsp.done) state_next = ST_DRAW;
      ST_DRAW: begin
        mul_start  = 1'b1;
        mul_a      = w1;
        mul_b      = 64'd5;
        state_next = ST_MUL_A;
      end
      ST_MUL_A: if (mul_done) begin
        mul_start  = 1'b1;
        mul_a      = rotl64(mul_p, 7);
        mul_b      = 64'd9;
        state_next = ST_MUL_B;
      end
      ST_MUL_B: if (mul_done) begin
        if (thr_phase) state_next = ST_MOD_START;
        else state_next = ST_OUT;
      end
      ST_MOD_START: begin
        if (reject) state_next = ST_DRAW;
        else begin
          dreq.start    = 1'b1;
          dreq.dividend = wide ? drawv : {32'd0, draw32};
          state_next    = ST_MOD_WAIT;
        end
      end
      ST_MOD_WAIT: if (drsp.done) state_next = ST_OUT;
      ST_SM_ADV: begin
        mul_start  = 1'b1;
        mul_a      = smv_adv ^ (smv_adv >> 30);
        mul_b      = SM_MUL_A;
        state_next = ST_SM_MUL_A;
      end
      ST_SM_MUL_A: if (mul_done) begin
        mul_start  = 1'b1;
        mul_a      = mul_p ^ (mul_p >> 27);
        mul_b      = SM_MUL_B;
        state_next = ST_SM_MUL_B;
      end
      ST_SM_MUL_B: if (mul_done) state_next = ST_SM_FIN;
      ST_SM_FIN: state_next = (idx == 2'd3) ? ST_IDLE : ST_SM_ADV;
      ST_OUT: if (!out_stall) state_next = ST_IDLE;
      ST_READ_OUT: if (!out_stall && idx == 2'd3) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  assign out_valid = (state == ST_OUT) || (state == ST_READ_OUT);
  assign last      = (state == ST_OUT) || (idx == 2'd3);
  always_comb begin
    if (state == ST_READ_OUT) begin
      case (idx)
        2'd0:    value = w0;
        2'd1:    value = w1;
        2'd2:    value = w2;
        default: value = w3;
      endcase
    end else begin
      value = res;
    end
  end

  logic [63:0] sm_out;
  assign sm_out = mul_p ^ (mul_p >> 31);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      w0 <= RST_W0; w1 <= RST_W1; w2 <= RST_W2; w3 <= RST_W3;
      idx <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: if (valid) begin
          cur_op    <= op_t'(op);
          lo_r      <= lower_bound;
          idx       <= '0;
          thr_phase <= 1'b0;
          case (op)
            OP_LIM32: begin
              wide <= 1'b0; lo_r <= '0;
              limit <= {32'd0, hi32};
              if (hi32 == 32'd0 || hi32[31]) res <= '0;
              else thr_phase <= 1'b1;
            end
            OP_RNG32: begin
              wide <= 1'b0;
              limit <= {32'd0, d32};
              if (rng32_empty) res <= {{32{lo32[31]}}, lo32};
              else thr_phase <= 1'b1;
            end
            OP_LIM64: begin
              wide <= 1'b1; lo_r <= '0;
              limit <= upper_bound;
              if (upper_bound == 64'sd0 || upper_bound[63]) res <= '0;
              else thr_phase <= 1'b1;
            end
            OP_RNG64: begin
              wide <= 1'b1;
              limit <= d64;
              if (rng64_empty) res <= lower_bound;
              else thr_phase <= 1'b1;
            end
            OP_RESEED: smv <= seed_reg;
            OP_LOAD: begin
              if (load_zero) smv <= 64'd1;
              else begin
                w0 <= lw0; w1 <= lw1; w2 <= lw2; w3 <= lw3;
              end
            end
            default: ;
          endcase
        end
        ST_THR_WAIT: if (drsp.done)
          thr <= (wide ? 64'hFFFFFFFFFFFFFFFF : 64'h00000000FFFFFFFF) - drsp.rem;
        ST_DRAW: begin
          w2 <= w2 ^ w0 ^ (w1 << 17);
          w3 <= rotl64(w3 ^ w1, 45);
          w1 <= w1 ^ w2 ^ w0;
          w0 <= w0 ^ w3 ^ w1;
        end
        ST_MUL_B: if (mul_done) begin
          drawv <= mul_p;
          case (cur_op)
            OP_SINGLE: res <= mul_p >> 41;
            OP_DOUBLE: res <= mul_p >> 12;
            OP_BOOL:   res <= mul_p >> 63;
            default:   res <= mul_p;
          endcase
        end
        ST_MOD_WAIT: if (drsp.done) begin
          if (wide) res <= lo_r + drsp.rem;
          else res <= 64'($signed(lo_r[31:0] + drsp.rem[31:0]));
        end
        ST_SM_ADV: smv <= smv_adv;
        ST_SM_FIN: begin
          case (idx)
            2'd0:    w0 <= sm_out;
            2'd1:    w1 <= sm_out;
            2'd2:    w2 <= sm_out;
            default: w3 <= sm_out;
          endcase
          idx <= idx + 2'd1;
        end
        ST_READ_OUT: if (!out_stall) idx <= idx + 2'd1;
        default: ;
      endcase
    end
  end

endmodule
